@@ sv/fpseq_pkg.sv @@
// Shared types and constants for the flight phase sequencer.
package fpseq_pkg;

    localparam int POS_W   = 24;
    localparam int QUAT_W  = 16;
    localparam int ALT_W   = 17;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 17;
    localparam int CFG_A_W = 3;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 144;

    localparam logic signed [QUAT_W-1:0] Q_ONE = 16'sd16384;

    localparam logic [ALT_W-1:0] TAKEOFF_CNT_MAX = {ALT_W{1'b1}};

    localparam logic [ALT_W-1:0] RST_LANDING_THRESHOLD = 17'd500;
    localparam logic [ALT_W-1:0] RST_TAKEOFF_ALTITUDE  = 17'd2000;
    localparam logic [CNT_W-1:0] RST_TAKEOFF_HOLD      = 16'd800;
    localparam logic [CNT_W-1:0] RST_OFFBOARD_PERIOD   = 16'd50;
    localparam logic [CNT_W-1:0] RST_ARM_PERIOD        = 16'd100;

    typedef enum logic [0:0] {
        OP_TICK     = 1'b0,
        OP_WAYPOINT = 1'b1
    } opcode_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_LANDING_THRESHOLD = 3'd0,
        CFG_TAKEOFF_ALTITUDE  = 3'd1,
        CFG_TAKEOFF_HOLD      = 3'd2,
        CFG_OFFBOARD_PERIOD   = 3'd3,
        CFG_ARM_PERIOD        = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_ACTIVATION = 3'd0,
        PH_TAKEOFF    = 3'd1,
        PH_HOVER      = 3'd2,
        PH_NAVIGATE   = 3'd3,
        PH_LANDING    = 3'd4
    } phase_t;

endpackage

@@ sv/flight_phase_sequencer.sv @@
// Flight phase sequencer: phase state, request retry timers and setpoint result register.
// A tick request's result is held in the result register and shown on m_tvalid.
// Throughput: one request per cycle while s_tready is high; waypoints only update state.
// s_tready is high whenever the result register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): activation phase, counters zero, target (0,0,2000) with
// identity orientation, registers at 500/2000/800/50/100, result register empty.
module flight_phase_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // offboard_mode[0], vehicle_armed[1], goal_x[25:2], goal_y[49:26], goal_z[73:50],
    // goal_qx[89:74], goal_qy[105:90], goal_qz[121:106], goal_qw[137:122], zero pad
    input  logic [fpseq_pkg::S_DATA_W-1:0]    s_tdata,
    // opcode[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // set_x[23:0], set_y[47:24], set_z[71:48], set_qx[87:72], set_qy[103:88],
    // set_qz[119:104], set_qw[135:120], ask_offboard[136], ask_arm[137],
    // flight_phase[140:138], zero pad
    output logic [fpseq_pkg::M_DATA_W-1:0]    m_tdata,
    // publish_setpoint[0]
    output logic                              m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [fpseq_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [fpseq_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int PW = fpseq_pkg::POS_W;
    localparam int QW = fpseq_pkg::QUAT_W;
    localparam int AW = fpseq_pkg::ALT_W;
    localparam int CW = fpseq_pkg::CNT_W;

    // configuration registers
    logic [AW-1:0] land_thr_reg;
    logic [AW-1:0] to_alt_reg;
    logic [CW-1:0] to_hold_reg;
    logic [CW-1:0] offb_period_reg;
    logic [CW-1:0] arm_period_reg;

    // sequencer state
    fpseq_pkg::phase_t phase_reg, phase_next;
    logic          traj_reg, traj_next;
    logic          land_pend_reg, land_pend_next;
    logic [AW-1:0] to_cnt_reg, to_cnt_next;
    logic [CW-1:0] offb_cnt_reg, offb_cnt_next;
    logic [CW-1:0] arm_cnt_reg, arm_cnt_next;
    logic signed [PW-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic signed [PW-1:0] tgt_x_next, tgt_y_next, tgt_z_next;
    logic signed [QW-1:0] tgt_qx_reg, tgt_qy_reg, tgt_qz_reg, tgt_qw_reg;
    logic signed [QW-1:0] tgt_qx_next, tgt_qy_next, tgt_qz_next, tgt_qw_next;

    // result register
    logic                 m_valid_reg;
    logic [fpseq_pkg::M_DATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    // input field views
    logic                 in_offb, in_armed;
    logic signed [PW-1:0] in_gx, in_gy, in_gz;
    logic signed [QW-1:0] in_qx, in_qy, in_qz, in_qw;
    fpseq_pkg::opcode_t   in_op;

    logic s_fire, tick_fire, wpt_fire;
    logic goal_is_land;
    logic [CW:0]   offb_inc, arm_inc;
    logic [CW-1:0] offb_per, arm_per;
    logic [AW-1:0] to_cnt_inc;

    // result fields
    logic                 res_pub, res_ask_off, res_ask_arm;
    logic signed [PW-1:0] res_x, res_y, res_z;
    logic signed [QW-1:0] res_qx, res_qy, res_qz, res_qw;
    logic [fpseq_pkg::M_DATA_W-1:0] res_data;

    assign in_op    = fpseq_pkg::opcode_t'(s_tuser);
    assign in_offb  = s_tdata[0];
    assign in_armed = s_tdata[1];
    assign in_gx    = s_tdata[25:2];
    assign in_gy    = s_tdata[49:26];
    assign in_gz    = s_tdata[73:50];
    assign in_qx    = s_tdata[89:74];
    assign in_qy    = s_tdata[105:90];
    assign in_qz    = s_tdata[121:106];
    assign in_qw    = s_tdata[137:122];

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign tick_fire = s_fire && (in_op == fpseq_pkg::OP_TICK);
    assign wpt_fire  = s_fire && (in_op == fpseq_pkg::OP_WAYPOINT);

    assign goal_is_land = $signed({in_gz[PW-1], in_gz}) < $signed({8'd0, land_thr_reg});

    // zero period behaves as period one
    assign offb_per = (offb_period_reg == '0) ? CW'(1) : offb_period_reg;
    assign arm_per  = (arm_period_reg == '0) ? CW'(1) : arm_period_reg;
    assign offb_inc = {1'b0, offb_cnt_reg} + (CW+1)'(1);
    assign arm_inc  = {1'b0, arm_cnt_reg} + (CW+1)'(1);
    assign offb_cnt_next = (offb_inc >= {1'b0, offb_per}) ? '0 : offb_inc[CW-1:0];
    assign arm_cnt_next  = (arm_inc >= {1'b0, arm_per}) ? '0 : arm_inc[CW-1:0];

    // saturate takeoff count
    assign to_cnt_inc = (to_cnt_reg < fpseq_pkg::TAKEOFF_CNT_MAX) ? to_cnt_reg + AW'(1)
                                                                  : to_cnt_reg;

    // next state for a tick request
    always_comb begin
        phase_next  = phase_reg;
        to_cnt_next = to_cnt_reg;
        unique case (phase_reg)
            fpseq_pkg::PH_ACTIVATION: begin
                if (in_offb && in_armed) begin
                    phase_next = fpseq_pkg::PH_TAKEOFF;
                end
            end
            fpseq_pkg::PH_TAKEOFF: begin
                to_cnt_next = to_cnt_inc;
                if (to_cnt_inc > {1'b0, to_hold_reg}) begin
                    phase_next  = fpseq_pkg::PH_HOVER;
                    to_cnt_next = '0;
                end
            end
            fpseq_pkg::PH_HOVER: begin
                if (land_pend_reg) begin
                    phase_next = fpseq_pkg::PH_LANDING;
                end else if (traj_reg) begin
                    phase_next = fpseq_pkg::PH_NAVIGATE;
                end
            end
            fpseq_pkg::PH_NAVIGATE: begin
                if (land_pend_reg && !traj_reg) begin
                    phase_next = fpseq_pkg::PH_LANDING;
                end
            end
            default: begin
                if (!land_pend_reg && traj_reg) begin
                    phase_next  = fpseq_pkg::PH_TAKEOFF;
                    to_cnt_next = '0;
                end
            end
        endcase
    end

    // result for a tick request
    always_comb begin
        res_pub     = 1'b0;
        res_ask_off = 1'b0;
        res_ask_arm = 1'b0;
        res_x  = '0;
        res_y  = '0;
        res_z  = '0;
        res_qx = '0;
        res_qy = '0;
        res_qz = '0;
        res_qw = '0;
        unique case (phase_reg)
            fpseq_pkg::PH_ACTIVATION: begin
                res_pub = 1'b1;
                res_qw  = fpseq_pkg::Q_ONE;
                if (!(in_offb && in_armed)) begin
                    res_ask_off = (offb_cnt_next == '0) && !in_offb;
                    res_ask_arm = (arm_cnt_next == '0) && !in_armed;
                end
            end
            fpseq_pkg::PH_TAKEOFF, fpseq_pkg::PH_HOVER: begin
                res_pub = 1'b1;
                res_z   = PW'(to_alt_reg);
                res_qw  = fpseq_pkg::Q_ONE;
            end
            fpseq_pkg::PH_NAVIGATE: begin
                if (!(land_pend_reg && !traj_reg)) begin
                    res_pub = 1'b1;
                    res_x   = tgt_x_reg;
                    res_y   = tgt_y_reg;
                    res_z   = tgt_z_reg;
                    res_qx  = tgt_qx_reg;
                    res_qy  = tgt_qy_reg;
                    res_qz  = tgt_qz_reg;
                    res_qw  = tgt_qw_reg;
                end
            end
            default: begin
                res_pub = 1'b0;
            end
        endcase
    end

    assign res_data = {3'd0, phase_next, res_ask_arm, res_ask_off,
                       res_qw, res_qz, res_qy, res_qx, res_z, res_y, res_x};

    // waypoint target capture
    always_comb begin
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        tgt_z_next  = tgt_z_reg;
        tgt_qx_next = tgt_qx_reg;
        tgt_qy_next = tgt_qy_reg;
        tgt_qz_next = tgt_qz_reg;
        tgt_qw_next = tgt_qw_reg;
        traj_next      = traj_reg;
        land_pend_next = land_pend_reg;
        if (goal_is_land) begin
            traj_next      = 1'b0;
            land_pend_next = 1'b1;
        end else begin
            tgt_x_next  = in_gx;
            tgt_y_next  = in_gy;
            tgt_z_next  = in_gz;
            tgt_qx_next = in_qx;
            tgt_qy_next = in_qy;
            tgt_qz_next = in_qz;
            tgt_qw_next = in_qw;
            traj_next      = 1'b1;
            land_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            land_thr_reg    <= fpseq_pkg::RST_LANDING_THRESHOLD;
            to_alt_reg      <= fpseq_pkg::RST_TAKEOFF_ALTITUDE;
            to_hold_reg     <= fpseq_pkg::RST_TAKEOFF_HOLD;
            offb_period_reg <= fpseq_pkg::RST_OFFBOARD_PERIOD;
            arm_period_reg  <= fpseq_pkg::RST_ARM_PERIOD;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                fpseq_pkg::CFG_LANDING_THRESHOLD: land_thr_reg    <= cfg_wdata;
                fpseq_pkg::CFG_TAKEOFF_ALTITUDE:  to_alt_reg      <= cfg_wdata;
                fpseq_pkg::CFG_TAKEOFF_HOLD:      to_hold_reg     <= cfg_wdata[CW-1:0];
                fpseq_pkg::CFG_OFFBOARD_PERIOD:   offb_period_reg <= cfg_wdata[CW-1:0];
                fpseq_pkg::CFG_ARM_PERIOD:        arm_period_reg  <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= fpseq_pkg::PH_ACTIVATION;
            traj_reg      <= 1'b0;
            land_pend_reg <= 1'b0;
            to_cnt_reg    <= '0;
            offb_cnt_reg  <= '0;
            arm_cnt_reg   <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            tgt_z_reg     <= PW'(fpseq_pkg::RST_TAKEOFF_ALTITUDE);
            tgt_qx_reg    <= '0;
            tgt_qy_reg    <= '0;
            tgt_qz_reg    <= '0;
            tgt_qw_reg    <= fpseq_pkg::Q_ONE;
        end else if (tick_fire) begin
            phase_reg    <= phase_next;
            to_cnt_reg   <= to_cnt_next;
            offb_cnt_reg <= offb_cnt_next;
            arm_cnt_reg  <= arm_cnt_next;
        end else if (wpt_fire) begin
            // landing goals force the landing phase from anywhere
            if (goal_is_land) begin
                phase_reg <= fpseq_pkg::PH_LANDING;
            end
            traj_reg      <= traj_next;
            land_pend_reg <= land_pend_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            tgt_z_reg     <= tgt_z_next;
            tgt_qx_reg    <= tgt_qx_next;
            tgt_qy_reg    <= tgt_qy_next;
            tgt_qz_reg    <= tgt_qz_next;
            tgt_qw_reg    <= tgt_qw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            m_data_reg <= res_data;
            m_user_reg <= res_pub;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_tick_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_fire |=> m_tvalid)
        else $error("tick request gave no result");

    a_no_setpoint_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[135:0] == '0))
        else $error("setpoint fields not zero without publish");

    a_ask_only_activation: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[136] || m_tdata[137]))
            |-> (m_tdata[140:138] == fpseq_pkg::PH_ACTIVATION))
        else $error("request flag outside activation");

    a_land_goal_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (wpt_fire && goal_is_land) |=> (phase_reg == fpseq_pkg::PH_LANDING) && land_pend_reg)
        else $error("landing goal did not force landing");
`endif

endmodule
